// ===== rtl/fm_tuner_preset_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// FM tuner preset table assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef FM_TUNER_PRESET_TABLE_UNIT_ASSERT_SVH
`define FM_TUNER_PRESET_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define FTPT_ASRT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftpt: check failed");

// next-cycle implication
`define FTPT_ASRT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftpt: check failed");

`endif

// ===== rtl/ftpt_pkg.sv =====
// ----------------------------------------------------------------------------
// FM tuner preset table package
// Widths, reset values, codes and the retune rule shared by the block.
// ----------------------------------------------------------------------------
package ftpt_pkg;

	localparam int STATION_COUNT_DEF = 64;

	localparam int FREQ_W    = 16;
	localparam int STEP_W    = 10;
	localparam int MODE_W    = 3;
	localparam int IDX_W     = 6;
	localparam int DIV_W     = 14;
	localparam int SLOT_W    = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CAND_W    = 18;
	localparam int PROD_W    = 30;

	localparam int DIV_MUL   = 10000;
	localparam int DIV_OFS   = 225000;
	localparam int DIV_SHIFT = 13;

	localparam logic [FREQ_W-1:0] EMPTY_FREQ   = 16'hFFFF;
	localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 16'd8750;
	localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 16'd10800;
	localparam logic [STEP_W-1:0] FREQ_STEP_RST = 10'd10;

	typedef enum logic [MODE_W-1:0] {
		MODE_SET     = 3'd0,
		MODE_STEP_UP = 3'd1,
		MODE_STEP_DN = 3'd2,
		MODE_SCAN_UP = 3'd3,
		MODE_SCAN_DN = 3'd4,
		MODE_LOAD    = 3'd5,
		MODE_STORE   = 3'd6,
		MODE_QUERY   = 3'd7
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREQ_MIN  = 2'd0,
		CFG_FREQ_MAX  = 2'd1,
		CFG_FREQ_STEP = 2'd2
	} cfg_reg_t;

	// above max wraps to min, then below min wraps to max
	function automatic logic [FREQ_W-1:0] retune_f(
		input logic signed [CAND_W-1:0] cand,
		input logic [FREQ_W-1:0] lo,
		input logic [FREQ_W-1:0] hi
	);
		logic signed [CAND_W-1:0] c;
		c = cand;
		if (c > $signed({2'b00, hi})) begin
			c = $signed({2'b00, lo});
		end
		if (c < $signed({2'b00, lo})) begin
			c = $signed({2'b00, hi});
		end
		return c[FREQ_W-1:0];
	endfunction

endpackage

// ===== rtl/ftpt_ram.sv =====
// ----------------------------------------------------------------------------
// FTPT generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ftpt_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                       wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                       rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fm_tuner_preset_table_unit.sv =====
// One request at a time; throughput is set by the preset table walk, one entry
// per cycle through the single read port of the table RAM.
// Reset: limits 8750/10800, step 10, tuned frequency 8750; per-entry valid bits
// clear at once so every preset reads empty, with no clearing pass.
// ----------------------------------------------------------------------------
// FM tuner preset table unit
// Keeps the tuned frequency and a sorted preset table, reports PLL divider,
// retune flag and preset slot per request.
// ----------------------------------------------------------------------------
module fm_tuner_preset_table_unit #(
	parameter int StationCount = ftpt_pkg::STATION_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ftpt_pkg::MODE_W-1:0]       mode,
	input  logic [ftpt_pkg::FREQ_W-1:0]       freq_value,
	input  logic [ftpt_pkg::IDX_W-1:0]        station_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              tuner_write,
	output logic [ftpt_pkg::DIV_W-1:0]        tuning_divider,
	output logic [ftpt_pkg::FREQ_W-1:0]       current_freq,
	output logic [ftpt_pkg::SLOT_W-1:0]       station_number,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ftpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ftpt_pkg::FREQ_W-1:0]       cfg_data
);

	import ftpt_pkg::*;

	localparam int IW = (StationCount > 1) ? $clog2(StationCount) : 1;
	localparam int CW = $clog2(StationCount + 1);
	localparam logic [CW-1:0] CntEnd  = CW'(StationCount);
	localparam logic [IW-1:0] LastIdx = IW'(StationCount - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EXEC  = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_WALK  = 7'b0001000,
		ST_SHIFT = 7'b0010000,
		ST_MUL   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		WK_SCAN = 2'd0,
		WK_FIND = 2'd1,
		WK_SLOT = 2'd2
	} walk_t;

	state_t                    state_q;
	walk_t                     walk_q;
	mode_t                     mode_q;
	logic [FREQ_W-1:0]         fval_q;
	logic [IDX_W-1:0]          idx_q;
	logic [FREQ_W-1:0]         freq_min_q;
	logic [FREQ_W-1:0]         freq_max_q;
	logic [STEP_W-1:0]         freq_step_q;
	logic [FREQ_W-1:0]         tuned_q;
	logic [StationCount-1:0]   valid_q;
	logic [CW-1:0]             cnt_q;
	logic                      rd_vld_s1;
	logic [IW-1:0]             rd_idx_s1;
	logic                      rd_vbit_s1;
	logic [FREQ_W-1:0]         found_q;
	logic [FREQ_W-1:0]         carry_q;
	logic                      del_q;
	logic                      wr_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [PROD_W-1:0]         prod_q;
	logic                      out_valid_q;
	logic                      out_wr_q;
	logic [DIV_W-1:0]          out_div_q;
	logic [FREQ_W-1:0]         out_freq_q;
	logic [SLOT_W-1:0]         out_slot_q;

	logic [IW-1:0]             rd_addr;
	logic [FREQ_W-1:0]         rd_data;
	logic [FREQ_W-1:0]         rd_entry;
	logic                      issue;
	logic                      rd_last;
	logic                      walk_hit;
	logic                      walk_end;
	logic [FREQ_W-1:0]         found_nxt;
	logic                      ram_we;
	logic [IW-1:0]             ram_waddr;
	logic [FREQ_W-1:0]         ram_wdata;
	logic                      idx_ok;
	logic [PROD_W-1:0]         div_sum;
	logic                      shift_done;

	ftpt_ram #(
		.Width(FREQ_W),
		.Depth(StationCount)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign in_stall       = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign tuner_write    = out_wr_q;
	assign tuning_divider = out_div_q;
	assign current_freq   = out_freq_q;
	assign station_number = out_slot_q;

	assign rd_addr    = (state_q == ST_EXEC) ? IW'(idx_q) : cnt_q[IW-1:0];
	assign rd_entry   = rd_vbit_s1 ? rd_data : EMPTY_FREQ;
	assign issue      = ((state_q == ST_WALK) || (state_q == ST_SHIFT)) && (cnt_q != CntEnd);
	assign rd_last    = (rd_idx_s1 == LastIdx);
	assign walk_end   = (state_q == ST_WALK) && rd_vld_s1 && (walk_hit || rd_last);
	assign idx_ok     = (32'(idx_q) < StationCount);
	assign div_sum    = prod_q + PROD_W'(DIV_OFS);
	assign shift_done = (state_q == ST_SHIFT) && (cnt_q == CntEnd) && !rd_vld_s1;

	always_comb begin
		walk_hit  = 1'b0;
		found_nxt = found_q;
		if ((state_q == ST_WALK) && rd_vld_s1) begin
			unique case (walk_q)
				WK_SCAN: begin
					if (rd_entry != EMPTY_FREQ) begin
						if (mode_q == MODE_SCAN_UP) begin
							if (rd_entry > tuned_q) begin
								walk_hit  = 1'b1;
								found_nxt = rd_entry;
							end
						end else if (rd_entry < tuned_q) begin
							found_nxt = rd_entry;
						end else begin
							walk_hit = 1'b1;
						end
					end
				end
				WK_FIND: walk_hit = (rd_entry >= tuned_q);
				WK_SLOT: walk_hit = (rd_entry == tuned_q) && (tuned_q != EMPTY_FREQ);
				default: walk_hit = 1'b0;
			endcase
		end
	end

	// delete moves entry up by one slot, insert writes the carried value in place
	always_comb begin
		ram_we    = (state_q == ST_SHIFT) && rd_vld_s1;
		ram_waddr = del_q ? (rd_idx_s1 - 1'b1) : rd_idx_s1;
		ram_wdata = del_q ? rd_entry : carry_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walk_q      <= WK_SLOT;
			mode_q      <= MODE_QUERY;
			fval_q      <= '0;
			idx_q       <= '0;
			freq_min_q  <= FREQ_MIN_RST;
			freq_max_q  <= FREQ_MAX_RST;
			freq_step_q <= FREQ_STEP_RST;
			tuned_q     <= FREQ_MIN_RST;
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			rd_vbit_s1  <= 1'b0;
			found_q     <= '0;
			carry_q     <= '0;
			del_q       <= 1'b0;
			wr_q        <= 1'b0;
			slot_q      <= '0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			out_wr_q    <= 1'b0;
			out_div_q   <= '0;
			out_freq_q  <= '0;
			out_slot_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_FREQ_MIN:  freq_min_q  <= cfg_data;
					CFG_FREQ_MAX:  freq_max_q  <= cfg_data;
					CFG_FREQ_STEP: freq_step_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end

			rd_vbit_s1 <= valid_q[rd_addr];
			if (issue && !walk_end) begin
				rd_vld_s1 <= 1'b1;
				rd_idx_s1 <= cnt_q[IW-1:0];
				cnt_q     <= cnt_q + 1'b1;
			end else begin
				rd_vld_s1 <= 1'b0;
			end

			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode_t'(mode);
						fval_q  <= freq_value;
						idx_q   <= station_index;
						wr_q    <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q   <= '0;
					walk_q  <= WK_SLOT;
					state_q <= ST_WALK;
					unique case (mode_q)
						MODE_SET: begin
							tuned_q <= retune_f($signed({2'b00, fval_q}), freq_min_q,
								freq_max_q);
							wr_q    <= 1'b1;
						end
						MODE_STEP_UP: begin
							tuned_q <= retune_f($signed({2'b00, tuned_q})
								+ $signed({8'b0, freq_step_q}), freq_min_q, freq_max_q);
							wr_q    <= 1'b1;
						end
						MODE_STEP_DN: begin
							tuned_q <= retune_f($signed({2'b00, tuned_q})
								- $signed({8'b0, freq_step_q}), freq_min_q, freq_max_q);
							wr_q    <= 1'b1;
						end
						MODE_SCAN_UP, MODE_SCAN_DN: begin
							found_q <= tuned_q;
							walk_q  <= WK_SCAN;
						end
						MODE_LOAD: begin
							if (idx_ok) begin
								state_q <= ST_LOAD;
							end
						end
						MODE_STORE: begin
							if (tuned_q != EMPTY_FREQ) begin
								walk_q <= WK_FIND;
							end
						end
						MODE_QUERY: ;
						default: ;
					endcase
				end
				ST_LOAD: begin
					if (rd_entry != EMPTY_FREQ) begin
						tuned_q <= retune_f($signed({2'b00, rd_entry}), freq_min_q,
							freq_max_q);
						wr_q    <= 1'b1;
					end
					cnt_q   <= '0;
					walk_q  <= WK_SLOT;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if ((walk_q == WK_SCAN) && rd_vld_s1) begin
						found_q <= found_nxt;
					end
					if (walk_end) begin
						unique case (walk_q)
							WK_SCAN: begin
								tuned_q <= retune_f($signed({2'b00, found_nxt}), freq_min_q,
									freq_max_q);
								wr_q    <= 1'b1;
								cnt_q   <= '0;
								walk_q  <= WK_SLOT;
							end
							WK_FIND: begin
								if (walk_hit) begin
									del_q   <= (rd_entry == tuned_q);
									carry_q <= tuned_q;
									cnt_q   <= CW'(rd_idx_s1)
										+ ((rd_entry == tuned_q) ? CW'(1) : '0);
									state_q <= ST_SHIFT;
								end else begin
									cnt_q  <= '0;
									walk_q <= WK_SLOT;
								end
							end
							WK_SLOT: begin
								slot_q  <= walk_hit ? SLOT_W'({1'b0, rd_idx_s1} + 1'b1) : '0;
								state_q <= ST_MUL;
							end
							default: state_q <= ST_MUL;
						endcase
					end
				end
				ST_SHIFT: begin
					if (rd_vld_s1 && !del_q) begin
						carry_q <= rd_entry;
					end
					if (shift_done) begin
						if (del_q) begin
							valid_q[LastIdx] <= 1'b0;
						end
						cnt_q   <= '0;
						walk_q  <= WK_SLOT;
						state_q <= ST_WALK;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(tuned_q) * PROD_W'(DIV_MUL);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_wr_q    <= wr_q;
						out_div_q   <= div_sum[DIV_SHIFT+DIV_W-1:DIV_SHIFT];
						out_freq_q  <= tuned_q;
						out_slot_q  <= slot_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ftpt_chk.sv =====
// ----------------------------------------------------------------------------
// FTPT port checker
// Port-level checks on the tuner preset table unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "fm_tuner_preset_table_unit_assert.svh"

module ftpt_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           tuner_write,
	input logic [ftpt_pkg::DIV_W-1:0]     tuning_divider,
	input logic [ftpt_pkg::FREQ_W-1:0]    current_freq,
	input logic [ftpt_pkg::SLOT_W-1:0]    station_number
);

	import ftpt_pkg::*;

	logic [PROD_W-1:0] div_ref;

	assign div_ref = PROD_W'(current_freq) * PROD_W'(DIV_MUL) + PROD_W'(DIV_OFS);

	// busy right after a request is taken
	`FTPT_ASRT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)

	// a held result keeps its frequency, slot and retune flag
	`FTPT_ASRT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(current_freq) && $stable(station_number) && $stable(tuner_write))

	// divider follows the reported frequency whenever a result is valid
	`FTPT_ASRT_IMP(a_div_match, out_valid, tuning_divider == div_ref[DIV_SHIFT+DIV_W-1:DIV_SHIFT])

	// a new result only comes out of a request in progress
	`FTPT_ASRT_IMP(a_out_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind fm_tuner_preset_table_unit ftpt_chk u_ftpt_chk (.*);
